FILE: sv/zbl_screening_function_assert.svh
// ----------------------------------------------------------------------------
// ZBL screening function assertion macros
// Shared concurrent assertion forms used by the screening function top level.
// ----------------------------------------------------------------------------
`ifndef ZBL_SCREENING_FUNCTION_ASSERT_SVH
`define ZBL_SCREENING_FUNCTION_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define ZBL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zbl assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ZBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zbl assertion failed");

`endif

FILE: sv/zbl_pkg.sv
// ----------------------------------------------------------------------------
// ZBL screening function package
// Widths, register indexes, reset values and shared types of the block.
// ----------------------------------------------------------------------------
package zbl_pkg;

  localparam int TERMS      = 4;
  localparam int NREG       = 8;
  localparam int RATE_W     = 20;
  localparam int AMP_W      = 25;
  localparam int DIST_W     = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int P_W        = RATE_W + DIST_W;
  localparam int K_W        = 13;
  localparam int T_W        = 32;
  localparam int S_W        = 33;
  localparam int CA_W       = RATE_W + AMP_W - 16;
  localparam int STEPS      = 12;
  localparam int STEP_W     = 4;
  localparam int OUT_W      = 25;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_FIRST = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_FIRST  = 8'd4;

  localparam logic [31:0]      LOG2E_Q31  = 32'd3098164009;
  localparam logic [31:0]      LN2_Q32    = 32'd2977044472;
  localparam logic [S_W-1:0]   ONE_Q32    = 33'h1_0000_0000;
  localparam logic [OUT_W-1:0] SCREEN_MAX = 25'd16777216;
  localparam logic [OUT_W-1:0] SLOPE_MAX  = 25'd33554431;

  localparam logic [RATE_W-1:0] RATE_RST [4] = '{20'd209715, 20'd61755, 20'd26404, 20'd13212};
  localparam logic [AMP_W-1:0]  AMP_RST  [4] =
    '{25'd3049930, 25'd8554031, 25'd4700640, 25'd472614};

  typedef struct packed {
    logic [T_W-1:0] t;
    logic [K_W-1:0] k;
    logic [S_W-1:0] s;
  } lane_t;

  typedef lane_t lane_vec_t [TERMS];

  // Reciprocal floor(2^32 / i) of a series step divisor from 2 to 12; other values give zero.
  function automatic logic [31:0] recip(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/zbl_reduce.sv
// ----------------------------------------------------------------------------
// ZBL range reduction
// Splits rate times distance into a power of two and a remainder below ln 2.
// ----------------------------------------------------------------------------
module zbl_reduce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [zbl_pkg::DIST_W-1:0]    distance_i,
  input  logic [zbl_pkg::RATE_W-1:0]    rate_i [zbl_pkg::TERMS],
  output logic                          valid_o,
  output zbl_pkg::lane_vec_t            lane_o
);
  import zbl_pkg::*;

  logic           v1_q, v2_q, v3_q;
  logic [P_W-1:0] p1_q [TERMS];
  logic [P_W-1:0] p2_q [TERMS];
  logic [K_W-1:0] k2_q [TERMS];
  logic [K_W-1:0] k3_q [TERMS];
  logic [T_W-1:0] t3_q [TERMS];
  logic [63:0]    kprod [TERMS];
  logic [P_W:0]   m_w [TERMS];
  logic [P_W:0]   diff [TERMS];
  logic [T_W-1:0] t_d [TERMS];

  always_comb begin
    for (int i = 0; i < TERMS; i++) begin
      kprod[i] = 64'(p1_q[i][P_W-1:12]) * 64'(LOG2E_Q31);
      m_w[i]   = (P_W+1)'(k2_q[i]) * (P_W+1)'(LN2_Q32);
      diff[i]  = (P_W+1)'(p2_q[i]) - m_w[i];
      if ((P_W+1)'(p2_q[i]) < m_w[i]) begin
        t_d[i] = '0;
      end else if (diff[i][P_W:T_W] != '0) begin
        t_d[i] = '1;
      end else begin
        t_d[i] = diff[i][T_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < TERMS; i++) begin
        p1_q[i] <= P_W'(rate_i[i]) * P_W'(distance_i);
        p2_q[i] <= p1_q[i];
        k2_q[i] <= kprod[i][63:51];
        k3_q[i] <= k2_q[i];
        t3_q[i] <= t_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TERMS; i++) begin
      lane_o[i].t = t3_q[i];
      lane_o[i].k = k3_q[i];
      lane_o[i].s = ONE_Q32;
    end
  end

  assign valid_o = v3_q;

endmodule

FILE: sv/zbl_cell.sv
// ----------------------------------------------------------------------------
// ZBL series cell
// One Horner step of the exponential series, s = 1 - t * s / i, in three stages.
// ----------------------------------------------------------------------------
module zbl_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [zbl_pkg::STEP_W-1:0]  step_i,
  input  logic                        valid_i,
  input  zbl_pkg::lane_vec_t          lane_i,
  output logic                        valid_o,
  output zbl_pkg::lane_vec_t          lane_o
);
  import zbl_pkg::*;

  logic        va_q, vb_q, vc_q;
  lane_t       la_q [TERMS];
  lane_t       lb_q [TERMS];
  lane_t       lc_q [TERMS];
  logic [31:0] na_q [TERMS];
  logic [31:0] nb_q [TERMS];
  logic [31:0] qe_q [TERMS];
  logic [63:0] ts [TERMS];
  logic [31:0] n_d [TERMS];
  logic [63:0] nm [TERMS];
  logic [31:0] qe_d [TERMS];
  logic [5:0]  qi [TERMS];
  logic [5:0]  r6 [TERMS];
  logic [5:0]  i6, i12;
  logic [32:0] q_d [TERMS];

  assign i6  = 6'(step_i);
  assign i12 = 6'({step_i, 1'b0});

  always_comb begin
    for (int j = 0; j < TERMS; j++) begin
      ts[j]  = 64'(lane_i[j].t) * 64'(lane_i[j].s[31:0]);
      n_d[j] = lane_i[j].s[32] ? lane_i[j].t : ts[j][63:32];
      nm[j]  = 64'(na_q[j]) * 64'(recip(step_i));
      qe_d[j] = (step_i == STEP_W'(1)) ? na_q[j] : nm[j][63:32];
      qi[j]  = 6'(qe_q[j][5:0] * i6);
      r6[j]  = nb_q[j][5:0] - qi[j];
      q_d[j] = 33'(qe_q[j]) + 33'(r6[j] >= i6) + 33'(r6[j] >= i12);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < TERMS; j++) begin
        la_q[j]   <= lane_i[j];
        na_q[j]   <= n_d[j];
        lb_q[j]   <= la_q[j];
        nb_q[j]   <= na_q[j];
        qe_q[j]   <= qe_d[j];
        lc_q[j].t <= lb_q[j].t;
        lc_q[j].k <= lb_q[j].k;
        lc_q[j].s <= ONE_Q32 - q_d[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < TERMS; j++) begin
      lane_o[j] = lc_q[j];
    end
  end

  assign valid_o = vc_q;

endmodule

FILE: sv/zbl_combine.sv
// ----------------------------------------------------------------------------
// ZBL term combiner
// Weights each exponential, applies its power of two, sums, rounds, saturates.
// ----------------------------------------------------------------------------
module zbl_combine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  zbl_pkg::lane_vec_t          lane_i,
  input  logic [zbl_pkg::AMP_W-1:0]   amp_i [zbl_pkg::TERMS],
  input  logic [zbl_pkg::CA_W-1:0]    ca_i [zbl_pkg::TERMS],
  output logic                        valid_o,
  output logic [zbl_pkg::OUT_W-1:0]   screen_value_o,
  output logic [zbl_pkg::OUT_W-1:0]   neg_slope_o
);
  import zbl_pkg::*;

  localparam int PA_W = AMP_W + S_W;
  localparam int PD_W = CA_W + S_W;
  localparam int VS_W = PA_W - 24 + 3;
  localparam int DS_W = PD_W - 24 + 2;

  logic            v1_q, v2_q, v3_q;
  logic [PA_W-1:0] pa_q [TERMS];
  logic [PD_W-1:0] pd_q [TERMS];
  logic [K_W-1:0]  k_q [TERMS];
  logic [PA_W-1:0] pa_d [TERMS];
  logic [PD_W-1:0] pd_d [TERMS];
  logic [K_W:0]    sh [TERMS];
  logic [VS_W-1:0] vsum_d, vsum_q;
  logic [DS_W-1:0] dsum_d, dsum_q;
  logic [VS_W-9:0] v_r;
  logic [DS_W-9:0] d_r;
  logic [OUT_W-1:0] screen_q, slope_q;

  always_comb begin
    vsum_d = '0;
    dsum_d = '0;
    for (int i = 0; i < TERMS; i++) begin
      pa_d[i] = lane_i[i].s[32] ? PA_W'({amp_i[i], 32'd0})
                                : PA_W'(64'(amp_i[i]) * 64'(lane_i[i].s[31:0]));
      pd_d[i] = lane_i[i].s[32] ? PD_W'({ca_i[i], 32'd0})
                                : PD_W'(64'(ca_i[i]) * 64'(lane_i[i].s[31:0]));
      sh[i]   = (K_W+1)'(k_q[i]) + (K_W+1)'(24);
      if (sh[i] < (K_W+1)'(64)) begin
        vsum_d = vsum_d + VS_W'(pa_q[i] >> sh[i][5:0]);
        dsum_d = dsum_d + DS_W'(pd_q[i] >> sh[i][5:0]);
      end
    end
  end

  assign v_r = (VS_W-8)'((vsum_q + VS_W'(128)) >> 8);
  assign d_r = (DS_W-8)'((dsum_q + DS_W'(128)) >> 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < TERMS; i++) begin
        pa_q[i] <= pa_d[i];
        pd_q[i] <= pd_d[i];
        k_q[i]  <= lane_i[i].k;
      end
      vsum_q   <= vsum_d;
      dsum_q   <= dsum_d;
      screen_q <= (v_r > (VS_W-8)'(SCREEN_MAX)) ? SCREEN_MAX : OUT_W'(v_r);
      slope_q  <= (d_r > (DS_W-8)'(SLOPE_MAX)) ? SLOPE_MAX : OUT_W'(d_r);
    end
  end

  assign valid_o        = v3_q;
  assign screen_value_o = screen_q;
  assign neg_slope_o    = slope_q;

endmodule

FILE: sv/zbl_screening_function.sv
// ----------------------------------------------------------------------------
// ZBL universal screening function
// Evaluates phi(x) and -dphi/dx for one reduced distance per cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
// A distance enters on the input channel as one beat and leaves as one result
// beat carrying the screening value and the negated slope. The datapath is a
// fixed pipeline of 42 stages: three for range reduction, a chain of twelve
// series cells of three stages each, and three for weighting and summing.
// One beat is taken in every cycle while the result side keeps up. When the
// receiver stalls, the whole pipeline holds and the input channel stops
// accepting until the waiting result is taken. Reset empties the pipeline
// and loads the standard ZBL rates and amplitudes. The configuration channel
// is always ready. Writes are to be made by the user while the pipeline is
// empty, which the block does not enforce; an index beyond seven is ignored.
// ----------------------------------------------------------------------------
`include "zbl_screening_function_assert.svh"

module zbl_screening_function (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [zbl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [zbl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [zbl_pkg::DIST_W-1:0]      distance_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [zbl_pkg::OUT_W-1:0]       screen_value_o,
  output logic [zbl_pkg::OUT_W-1:0]       neg_slope_o
);
  import zbl_pkg::*;

  logic [RATE_W-1:0] rate_q [TERMS];
  logic [AMP_W-1:0]  amp_q [TERMS];
  logic [CA_W-1:0]   ca_q [TERMS];
  logic              en;
  logic              valid_chain [STEPS+1];
  lane_vec_t         lane_chain [STEPS+1];
  logic [P_W:0]      ca_prod [TERMS];

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TERMS; i++) begin
        rate_q[i] <= RATE_RST[i];
        amp_q[i]  <= AMP_RST[i];
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < TERMS; i++) begin
        if (cfg_index_i == REG_RATE_FIRST + CFG_IDX_W'(i)) begin
          rate_q[i] <= cfg_data_i[RATE_W-1:0];
        end
        if (cfg_index_i == REG_AMP_FIRST + CFG_IDX_W'(i)) begin
          amp_q[i] <= cfg_data_i[AMP_W-1:0];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TERMS; i++) begin
      ca_prod[i] = (P_W+1)'(rate_q[i]) * (P_W+1)'(amp_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TERMS; i++) begin
      ca_q[i] <= ca_prod[i][RATE_W+AMP_W-1:16];
    end
  end

  zbl_reduce u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .distance_i (distance_i),
    .rate_i     (rate_q),
    .valid_o    (valid_chain[0]),
    .lane_o     (lane_chain[0])
  );

  for (genvar j = 0; j < STEPS; j++) begin : g_cell
    zbl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_W'(STEPS - j)),
      .valid_i (valid_chain[j]),
      .lane_i  (lane_chain[j]),
      .valid_o (valid_chain[j+1]),
      .lane_o  (lane_chain[j+1])
    );
  end

  zbl_combine u_combine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (valid_chain[STEPS]),
    .lane_i         (lane_chain[STEPS]),
    .amp_i          (amp_q),
    .ca_i           (ca_q),
    .valid_o        (out_valid_o),
    .screen_value_o (screen_value_o),
    .neg_slope_o    (neg_slope_o)
  );

  `ZBL_ASSERT_SAME(a_screen_bound, out_valid_o, screen_value_o <= SCREEN_MAX)
  `ZBL_ASSERT_SAME(a_stall_blocks, out_valid_o && !out_ready_i, !in_ready_o)
  `ZBL_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(screen_value_o) && $stable(neg_slope_o))

endmodule

FILE: test/tb_zbl_screening_function.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ZBL screening function testbench
// Drives distances through the block under random idling on both channels and
// compares every result beat with an in-bench fixed-point evaluation of the
// screening value and negated slope, across several coefficient settings.
// ----------------------------------------------------------------------------
module tb_zbl_screening_function;
  import zbl_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] screen;
    logic [OUT_W-1:0] slope;
  } screen_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [DIST_W-1:0]     distance_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OUT_W-1:0]      screen_value_o;
  logic [OUT_W-1:0]      neg_slope_o;

  logic [RATE_W-1:0] rate_q [4];
  logic [AMP_W-1:0]  amp_q [4];
  screen_res_t       pending_q [$];
  int                mismatches = 0;
  bit                idle_on = 1'b1;

  zbl_screening_function dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic screen_res_t eval_screen(input logic [DIST_W-1:0] x);
    bit [63:0] p, q, k, m, t, s, ca, vsum, dsum, v, d;
    screen_res_t r;
    vsum = 0;
    dsum = 0;
    for (int j = 0; j < TERMS; j++) begin
      p = 64'(rate_q[j]) * 64'(x);
      q = p >> 12;
      k = (q * 64'(LOG2E_Q31)) >> 51;
      m = k * 64'(LN2_Q32);
      t = (p < m) ? 64'd0 : p - m;
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      s = 64'h1_0000_0000;
      for (int i = STEPS; i >= 1; i--) s = 64'h1_0000_0000 - (((t * s) >> 32) / i);
      ca = (64'(rate_q[j]) * 64'(amp_q[j])) >> 16;
      if (24 + k < 64) begin
        vsum += (64'(amp_q[j]) * s) >> (24 + k);
        dsum += (ca * s) >> (24 + k);
      end
    end
    v = (vsum + 128) >> 8;
    d = (dsum + 128) >> 8;
    if (v > 64'(SCREEN_MAX)) v = 64'(SCREEN_MAX);
    if (d > 64'(SLOPE_MAX)) d = 64'(SLOPE_MAX);
    r.screen = v[OUT_W-1:0];
    r.slope  = d[OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    screen_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat");
        mismatches++;
      end else begin
        e = pending_q.pop_front();
        if (screen_value_o !== e.screen) begin
          $error("screen_value expected %0d actual %0d", e.screen, screen_value_o);
          mismatches++;
        end
        if (neg_slope_o !== e.slope) begin
          $error("neg_slope expected %0d actual %0d", e.slope, neg_slope_o);
          mismatches++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) pending_q.push_back(eval_screen(distance_i));
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_distance(input logic [DIST_W-1:0] x);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    distance_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < REG_AMP_FIRST) rate_q[idx[1:0]] = data[RATE_W-1:0];
    else if (idx < NREG) amp_q[2'(idx - REG_AMP_FIRST)] = data[AMP_W-1:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    if ($urandom_range(0, 9) < 7) return DIST_W'($urandom_range(0, 1 << 21));
    return DIST_W'($urandom);
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_distance(pick_distance());
  endtask

  task automatic test_standard_coeffs();
    idle_on = 1'b0;
    send_distance('0);
    send_distance(24'd1);
    send_distance(24'hFFFFFF);
    send_distance(24'h800000);
    send_distance(24'h010000);
    send_distance(24'h0A0000);
    send_distance(24'h7FFFFF);
    send_distance(24'h555555);
    send_distance(24'hAAAAAA);
    send_random(40);
    idle_on = 1'b1;
    send_random(200);
    wait_results();
  endtask

  task automatic test_zero_rates();
    write_reg(REG_RATE_FIRST, '0);
    write_reg(REG_RATE_FIRST + CFG_IDX_W'(2), '0);
    send_distance('0);
    send_distance(24'hFFFFFF);
    send_random(80);
    wait_results();
  endtask

  task automatic test_extreme_coeffs();
    for (int j = 0; j < 4; j++) write_reg(REG_RATE_FIRST + CFG_IDX_W'(j), 32'hFFFFFFFF);
    for (int j = 0; j < 4; j++) write_reg(REG_AMP_FIRST + CFG_IDX_W'(j), 32'hFFFFFFFF);
    send_distance('0);
    send_distance(24'd1);
    send_distance(24'hFFFFFF);
    repeat (60) send_distance(DIST_W'($urandom_range(0, 4096)));
    wait_results();
    for (int j = 0; j < 4; j++) write_reg(REG_AMP_FIRST + CFG_IDX_W'(j), '0);
    send_random(20);
    wait_results();
  endtask

  task automatic test_ignored_index();
    write_reg(CFG_IDX_W'(NREG), 32'hFFFFFFFF);
    write_reg('1, 32'h12345678);
    send_random(20);
    wait_results();
  endtask

  task automatic test_random_coeffs();
    for (int round = 0; round < 5; round++) begin
      for (int j = 0; j < 4; j++) write_reg(REG_RATE_FIRST + CFG_IDX_W'(j), $urandom);
      for (int j = 0; j < 4; j++) write_reg(REG_AMP_FIRST + CFG_IDX_W'(j), $urandom);
      send_random(60);
      wait_results();
    end
  endtask

  initial begin
    for (int j = 0; j < 4; j++) begin
      rate_q[j] = RATE_RST[j];
      amp_q[j]  = AMP_RST[j];
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_standard_coeffs();
    test_zero_rates();
    test_extreme_coeffs();
    test_ignored_index();
    test_random_coeffs();
    wait_results();
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/zbl_pkg.sv
sv/zbl_reduce.sv
sv/zbl_cell.sv
sv/zbl_combine.sv
sv/zbl_screening_function.sv
test/tb_zbl_screening_function.sv
